### sv/psv_pkg.sv
package psv_pkg;

   localparam int DefLineDepth = 4096;

   localparam int ExciteW   = 16;
   localparam int SampleW   = 16;
   localparam int CoefW     = 18;
   localparam int DelayLenW = 13;
   localparam int StateW    = 32;
   localparam int CsrIndexW = 3;
   localparam int CsrDataW  = 18;

   // shared multiplier: coefficient times a 33-bit signed operand
   localparam int MulBW = 33;
   localparam int ProdW = CoefW + MulBW;
   localparam int AccW  = 51;

   localparam logic [CsrIndexW-1:0] CsrDelayLen = 3'd0;
   localparam logic [CsrIndexW-1:0] CsrTapCoef0 = 3'd1;
   localparam logic [CsrIndexW-1:0] CsrTapCoef1 = 3'd2;
   localparam logic [CsrIndexW-1:0] CsrTapCoef2 = 3'd3;
   localparam logic [CsrIndexW-1:0] CsrTapCoef3 = 3'd4;
   localparam logic [CsrIndexW-1:0] CsrDcGain   = 3'd5;
   localparam logic [CsrIndexW-1:0] CsrDcPole   = 3'd6;

   localparam logic [DelayLenW-1:0]    DelayLenRst = 13'd100;
   localparam logic signed [CoefW-1:0] DcGainRst   = 18'sd65536;
   localparam logic signed [CoefW-1:0] DcPoleRst   = 18'sd65000;

   localparam logic [1:0] MulTap  = 2'd0;
   localparam logic [1:0] MulPole = 2'd1;
   localparam logic [1:0] MulGain = 2'd2;

   typedef struct packed {
      logic       load;
      logic       clear_wr;
      logic       rd_en;
      logic       mul_en;
      logic [1:0] mul_sel;
      logic [1:0] tap_idx;
      logic       acc_init;
      logic       acc_add_tap;
      logic       acc_add_pole;
      logic       znew_en;
      logic       diff_en;
      logic       finish;
   } psv_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic out_free;
   } psv_status_type;

endpackage

### sv/psv_if.sv
interface psv_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [psv_pkg::ExciteW-1:0]  excite_in;

   modport source (output valid, output excite_in, input ready);
   modport sink (input valid, input excite_in, output ready);
endinterface

interface psv_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [psv_pkg::SampleW-1:0]  sample_out;

   modport source (output valid, output sample_out, input ready);
   modport sink (input valid, input sample_out, output ready);
endinterface

### sv/psv_ctrl.sv
module psv_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  psv_pkg::psv_status_type  status,
   output psv_pkg::psv_cmd_type     cmd
);
   import psv_pkg::*;

   localparam logic [1:0] SClear  = 2'd0;
   localparam logic [1:0] SIdle   = 2'd1;
   localparam logic [1:0] SRun    = 2'd2;
   localparam logic [1:0] SFinish = 2'd3;

   localparam logic [3:0] StepRd0   = 4'd1;
   localparam logic [3:0] StepRd1   = 4'd2;
   localparam logic [3:0] StepRd2   = 4'd3;
   localparam logic [3:0] StepRd3   = 4'd4;
   localparam logic [3:0] StepMac3  = 4'd5;
   localparam logic [3:0] StepPole  = 4'd6;
   localparam logic [3:0] StepSum   = 4'd7;
   localparam logic [3:0] StepRound = 4'd8;
   localparam logic [3:0] StepDiff  = 4'd9;
   localparam logic [3:0] StepGain  = 4'd10;

   logic [1:0] state_ff, state_in;
   logic [3:0] step_ff, step_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      step_in   = step_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         SClear: begin
            cmd.clear_wr = 1'b1;
            if (status.clear_last) begin
               state_in = SIdle;
            end
         end
         SIdle: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = SRun;
               step_in  = StepRd0;
            end
         end
         SRun: begin
            step_in = step_ff + 4'd1;
            unique case (step_ff)
               StepRd0: begin
                  cmd.rd_en    = 1'b1;
                  cmd.acc_init = 1'b1;
               end
               StepRd1: begin
                  cmd.rd_en   = 1'b1;
                  cmd.mul_en  = 1'b1;
                  cmd.mul_sel = MulTap;
                  cmd.tap_idx = 2'd0;
               end
               StepRd2: begin
                  cmd.rd_en       = 1'b1;
                  cmd.mul_en      = 1'b1;
                  cmd.mul_sel     = MulTap;
                  cmd.tap_idx     = 2'd1;
                  cmd.acc_add_tap = 1'b1;
               end
               StepRd3: begin
                  cmd.rd_en       = 1'b1;
                  cmd.mul_en      = 1'b1;
                  cmd.mul_sel     = MulTap;
                  cmd.tap_idx     = 2'd2;
                  cmd.acc_add_tap = 1'b1;
               end
               StepMac3: begin
                  cmd.mul_en      = 1'b1;
                  cmd.mul_sel     = MulTap;
                  cmd.tap_idx     = 2'd3;
                  cmd.acc_add_tap = 1'b1;
               end
               StepPole: begin
                  cmd.mul_en      = 1'b1;
                  cmd.mul_sel     = MulPole;
                  cmd.acc_add_tap = 1'b1;
               end
               StepSum: begin
                  cmd.acc_add_pole = 1'b1;
               end
               StepRound: begin
                  cmd.znew_en = 1'b1;
               end
               StepDiff: begin
                  cmd.diff_en = 1'b1;
               end
               StepGain: begin
                  cmd.mul_en  = 1'b1;
                  cmd.mul_sel = MulGain;
                  state_in    = SFinish;
               end
               default: begin
                  state_in = SFinish;
               end
            endcase
         end
         SFinish: begin
            // hold the result until the output register can take it
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = SIdle;
            end
         end
         default: begin
            state_in = SClear;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SClear;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

### sv/psv_dp.sv
module psv_dp #(
   parameter int LINE_DEPTH = psv_pkg::DefLineDepth
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  psv_pkg::psv_cmd_type                 cmd,
   output psv_pkg::psv_status_type              status,
   input  logic                                 csr_we,
   input  logic [psv_pkg::CsrIndexW-1:0]        csr_index,
   input  logic [psv_pkg::CsrDataW-1:0]         csr_wdata,
   input  logic signed [psv_pkg::ExciteW-1:0]   excite_in,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [psv_pkg::SampleW-1:0]   sample_out
);
   import psv_pkg::*;

   localparam int AW = $clog2(LINE_DEPTH);
   localparam int CW = (AW + 1 > DelayLenW) ? AW + 1 : DelayLenW;
   localparam logic [AW-1:0] LastAddr = AW'(LINE_DEPTH - 1);
   localparam logic [CW-1:0] DepthN   = CW'(LINE_DEPTH);
   localparam logic [CW:0]   DepthW   = (CW + 1)'(LINE_DEPTH);
   localparam int ZW = AccW - 16;
   localparam int YW = ProdW - 24;
   localparam logic signed [ZW-1:0] ZMax =
      {{(ZW - StateW){1'b0}}, 1'b0, {(StateW - 1){1'b1}}};
   localparam logic signed [ZW-1:0] ZMin =
      {{(ZW - StateW){1'b1}}, 1'b1, {(StateW - 1){1'b0}}};
   localparam logic signed [YW-1:0] YMax =
      {{(YW - SampleW){1'b0}}, 1'b0, {(SampleW - 1){1'b1}}};
   localparam logic signed [YW-1:0] YMin =
      {{(YW - SampleW){1'b1}}, 1'b1, {(SampleW - 1){1'b0}}};

   // configuration registers
   logic [DelayLenW-1:0]    delay_len_ff;
   logic signed [CoefW-1:0] tap_coef_ff [4];
   logic signed [CoefW-1:0] dc_gain_ff;
   logic signed [CoefW-1:0] dc_pole_ff;

   // loop state and work registers
   logic signed [SampleW-1:0] line_mem [LINE_DEPTH];
   logic [AW-1:0]             clr_addr_ff;
   logic [AW-1:0]             wp_ff, wp_in;
   logic [AW-1:0]             tap_addr_ff, tap_base, tap_dec;
   logic signed [ExciteW-1:0] excite_ff;
   logic signed [SampleW-1:0] rdata_ff;
   logic signed [ProdW-1:0]   prod_ff, prod_in;
   logic signed [AccW-1:0]    acc_ff, acc_in;
   logic signed [StateW-1:0]  znew_ff, znew_in;
   logic signed [StateW-1:0]  dc_state_ff;
   logic signed [MulBW-1:0]   diff_ff, diff_in;
   logic signed [SampleW-1:0] sample_out_ff, y_sat;
   logic                      full_ff;

   logic [CW-1:0]           dl_ext, n_len;
   logic [CW:0]             base_sum, base_mod;
   logic signed [CoefW-1:0] mul_a;
   logic signed [MulBW-1:0] mul_b;
   logic signed [AccW-1:0]  z_rnd;
   logic signed [ZW-1:0]    z_q;
   logic signed [ProdW-1:0] y_rnd;
   logic signed [YW-1:0]    y_q;
   logic                    mem_we;
   logic [AW-1:0]           mem_waddr;
   logic signed [SampleW-1:0] mem_wdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_len_ff   <= DelayLenRst;
         tap_coef_ff[0] <= '0;
         tap_coef_ff[1] <= '0;
         tap_coef_ff[2] <= '0;
         tap_coef_ff[3] <= '0;
         dc_gain_ff     <= DcGainRst;
         dc_pole_ff     <= DcPoleRst;
      end else if (csr_we) begin
         unique case (csr_index)
            CsrDelayLen: delay_len_ff   <= csr_wdata[DelayLenW-1:0];
            CsrTapCoef0: tap_coef_ff[0] <= signed'(csr_wdata);
            CsrTapCoef1: tap_coef_ff[1] <= signed'(csr_wdata);
            CsrTapCoef2: tap_coef_ff[2] <= signed'(csr_wdata);
            CsrTapCoef3: tap_coef_ff[3] <= signed'(csr_wdata);
            CsrDcGain:   dc_gain_ff     <= signed'(csr_wdata);
            CsrDcPole:   dc_pole_ff     <= signed'(csr_wdata);
            default: ;
         endcase
      end
   end

   // effective delay clamped to 1..LINE_DEPTH, first tap = new write slot - n
   always_comb begin
      dl_ext = CW'(delay_len_ff);
      if (dl_ext == '0) begin
         n_len = CW'(1);
      end else if (dl_ext > DepthN) begin
         n_len = DepthN;
      end else begin
         n_len = dl_ext;
      end
      wp_in    = (wp_ff == LastAddr) ? '0 : wp_ff + 1'b1;
      base_sum = (CW + 1)'(wp_in) + DepthW - {1'b0, n_len};
      base_mod = (base_sum >= DepthW) ? base_sum - DepthW : base_sum;
      tap_base = base_mod[AW-1:0];
      tap_dec  = (tap_addr_ff == '0) ? LastAddr : tap_addr_ff - 1'b1;
   end

   // shared multiplier
   always_comb begin
      unique case (cmd.mul_sel)
         MulTap: begin
            mul_a = tap_coef_ff[cmd.tap_idx];
            mul_b = {{(MulBW - SampleW){rdata_ff[SampleW-1]}}, rdata_ff};
         end
         MulPole: begin
            mul_a = dc_pole_ff;
            mul_b = {dc_state_ff[StateW-1], dc_state_ff};
         end
         default: begin
            mul_a = dc_gain_ff;
            mul_b = diff_ff;
         end
      endcase
      prod_in = mul_a * mul_b;
   end

   // accumulator in Q.24: excitation, taps (Q.16 shifted up), pole term
   always_comb begin
      priority if (cmd.acc_init) begin
         acc_in = {{(AccW - ExciteW - 24){excite_ff[ExciteW-1]}}, excite_ff, 24'd0};
      end else if (cmd.acc_add_tap) begin
         acc_in = acc_ff + (prod_ff <<< 8);
      end else if (cmd.acc_add_pole) begin
         acc_in = acc_ff + prod_ff;
      end else begin
         acc_in = acc_ff;
      end
   end

   // round half up to Q.8 and saturate to 32 bits
   always_comb begin
      z_rnd = acc_ff + AccW'(32768);
      z_q   = z_rnd[AccW-1:16];
      if (z_q > ZMax) begin
         znew_in = {1'b0, {(StateW - 1){1'b1}}};
      end else if (z_q < ZMin) begin
         znew_in = {1'b1, {(StateW - 1){1'b0}}};
      end else begin
         znew_in = z_q[StateW-1:0];
      end
      diff_in = {znew_ff[StateW-1], znew_ff} - {dc_state_ff[StateW-1], dc_state_ff};
   end

   // output: round half up to an integer and saturate to 16 bits
   always_comb begin
      y_rnd = prod_ff + ProdW'(8388608);
      y_q   = y_rnd[ProdW-1:24];
      if (y_q > YMax) begin
         y_sat = {1'b0, {(SampleW - 1){1'b1}}};
      end else if (y_q < YMin) begin
         y_sat = {1'b1, {(SampleW - 1){1'b0}}};
      end else begin
         y_sat = y_q[SampleW-1:0];
      end
   end

   assign mem_we    = cmd.clear_wr | cmd.finish;
   assign mem_waddr = cmd.clear_wr ? clr_addr_ff : wp_ff;
   assign mem_wdata = cmd.clear_wr ? '0 : y_sat;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.rd_en) begin
         rdata_ff <= line_mem[tap_addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         wp_ff       <= '0;
         dc_state_ff <= '0;
         full_ff     <= 1'b0;
      end else begin
         if (cmd.clear_wr) begin
            clr_addr_ff <= (clr_addr_ff == LastAddr) ? '0 : clr_addr_ff + 1'b1;
         end
         if (cmd.load) begin
            wp_ff <= wp_in;
         end
         if (cmd.diff_en) begin
            dc_state_ff <= znew_ff;
         end
         if (cmd.finish) begin
            full_ff <= 1'b1;
         end else if (rsp_ready) begin
            full_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         tap_addr_ff <= tap_base;
         excite_ff   <= excite_in;
      end else if (cmd.rd_en) begin
         tap_addr_ff <= tap_dec;
      end
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      acc_ff <= acc_in;
      if (cmd.znew_en) begin
         znew_ff <= znew_in;
      end
      if (cmd.diff_en) begin
         diff_ff <= diff_in;
      end
      if (cmd.finish) begin
         sample_out_ff <= y_sat;
      end
   end

   assign status.clear_last = (clr_addr_ff == LastAddr);
   assign status.out_free   = ~full_ff | rsp_ready;
   assign rsp_valid         = full_ff;
   assign sample_out        = sample_out_ff;

endmodule

### sv/plucked_string_voice_core.sv
// Channel   Dir  Payload                    Handshake
// req_ch    in   excite_in  (s16)           valid/ready
// rsp_ch    out  sample_out (s16)           valid/ready
// csr_*     in   index 3b, data 18b         write enable, no wait
//
// One word at a time: accept, four delay-line reads through the single
// memory read port overlapped with the shared 18x33 multiplier, pole term,
// rounding, difference, gain multiply and the write-back/result cycle.
// Synchronous active-high reset; after reset the delay line is cleared one
// entry per cycle, all LINE_DEPTH entries, with req_ch.ready low.
// A finished word sits in the output register; a stalled rsp_ch holds the
// next word in its last cycle until the register frees.
module plucked_string_voice_core #(
   parameter int LINE_DEPTH = psv_pkg::DefLineDepth
) (
   input  logic                           clock,
   input  logic                           reset,
   psv_req_if.sink                        req_ch,
   psv_rsp_if.source                      rsp_ch,
   input  logic                           csr_we,
   input  logic [psv_pkg::CsrIndexW-1:0]  csr_index,
   input  logic [psv_pkg::CsrDataW-1:0]   csr_wdata
);
   import psv_pkg::*;

   psv_cmd_type    cmd;
   psv_status_type status;

   psv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   psv_dp #(
      .LINE_DEPTH (LINE_DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .excite_in  (req_ch.excite_in),
      .rsp_valid  (rsp_ch.valid),
      .rsp_ready  (rsp_ch.ready),
      .sample_out (rsp_ch.sample_out)
   );

`ifndef SYNTHESIS
   a_one_word_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("input accepted while a word is in flight");

   a_clear_blocks_input: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_wr |-> !req_ch.ready)
      else $error("input ready during delay-line clear");

   a_result_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_ch.valid) |-> $past(cmd.finish))
      else $error("result valid without a finished word");
`endif

endmodule
